>>> sv/ttp_pkg.sv
// ----------------------------------------------------------------------------
// ttp_pkg
// Shared types and constants of the task timing profiler: event codes,
// status flag positions, metric slots and controller/datapath bundles.
// ----------------------------------------------------------------------------
package ttp_pkg;

	// history ring depth default
	localparam int HIST_DEPTH_DEF = 64;

	// range threshold after reset
	localparam logic [23:0] THRESH_RESET = 24'hC0_0000;

	// event codes
	localparam logic [2:0] FN_START = 3'd0;
	localparam logic [2:0] FN_YREQ  = 3'd1;
	localparam logic [2:0] FN_PDONE = 3'd2;
	localparam logic [2:0] FN_RDONE = 3'd3;
	localparam logic [2:0] FN_QUERY = 3'd4;
	localparam logic [2:0] FN_CLEAR = 3'd5;

	// task types on start
	localparam logic [1:0] TT_AUDIO    = 2'd0;
	localparam logic [1:0] TT_GRAPHICS = 2'd1;

	// status flag bit positions
	localparam int FL_RUN   = 0;
	localparam int FL_PAUSE = 1;
	localparam int FL_YPEND = 2;
	localparam int FL_PDONE = 3;
	localparam int FL_RDONE = 4;
	localparam int FL_VALID = 5;

	// metric slots
	localparam int NUM_METRICS = 16;
	localparam logic [3:0] M_SEQ    = 4'd0;
	localparam logic [3:0] M_TOTAL  = 4'd1;
	localparam logic [3:0] M_PROC   = 4'd2;
	localparam logic [3:0] M_AUDIO  = 4'd3;
	localparam logic [3:0] M_YTICKS = 4'd4;
	localparam logic [3:0] M_YCOUNT = 4'd5;
	localparam logic [3:0] M_YLAT   = 4'd6;
	localparam logic [3:0] M_REND   = 4'd7;
	localparam logic [3:0] M_RCLK   = 4'd8;
	localparam logic [3:0] M_RCMD   = 4'd9;
	localparam logic [3:0] M_RPIPE  = 4'd10;
	localparam logic [3:0] M_RTMEM  = 4'd11;
	localparam logic [3:0] M_RANGE  = 4'd12;
	localparam logic [3:0] M_HCOUNT = 4'd13;
	localparam logic [3:0] M_AVG    = 4'd14;
	localparam logic [3:0] M_MAX    = 4'd15;

	// controller to datapath commands
	typedef struct packed {
		logic exec;
		logic pub_read;
		logic pub_write;
		logic div_run;
		logic max_run;
		logic finish;
		logic q_load;
	} ctrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic pub_need;
		logic query;
		logic div_done;
		logic max_done;
		logic out_free;
		logic q_last;
	} dp_stat_t;

endpackage

>>> sv/ttp_ctrl.sv
// ----------------------------------------------------------------------------
// ttp_ctrl
// Sequencer of the profiler: takes events, steps the publish sequence
// (ring read, ring write, division, maximum sweep, copy) and the query burst.
// ----------------------------------------------------------------------------
module ttp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  ttp_pkg::dp_stat_t  stat,
	output ttp_pkg::ctrl_cmd_t cmd,
	output logic               in_stall
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PRD  = 3'd1;
	localparam logic [2:0] ST_PWR  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_MAX  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;
	localparam logic [2:0] ST_QRY  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_n;

	// next state and commands
	always_comb begin
		state_n = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.exec = in_valid;
				if (in_valid && stat.pub_need) begin
					state_n = ST_PRD;
				end else if (in_valid && stat.query) begin
					state_n = ST_QRY;
				end
			end
			ST_PRD: begin
				cmd.pub_read = 1'b1;
				state_n      = ST_PWR;
			end
			ST_PWR: begin
				cmd.pub_write = 1'b1;
				state_n       = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_run = 1'b1;
				if (stat.div_done) begin
					state_n = ST_MAX;
				end
			end
			ST_MAX: begin
				cmd.max_run = 1'b1;
				if (stat.max_done) begin
					state_n = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_n    = ST_IDLE;
			end
			ST_QRY: begin
				cmd.q_load = stat.out_free;
				if (stat.out_free && stat.q_last) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// hold input while a sequence runs
	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

>>> sv/ttp_dp.sv
// ----------------------------------------------------------------------------
// ttp_dp
// Datapath of the profiler: task state, active and latest metrics, history
// ring memory, serial divider for the average, maximum sweep, output register.
// ----------------------------------------------------------------------------
module ttp_dp #(
	parameter int HISTORY_DEPTH = ttp_pkg::HIST_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ttp_pkg::ctrl_cmd_t cmd,
	output ttp_pkg::dp_stat_t  stat,
	input  logic [23:0]        range_threshold,
	input  logic [2:0]         func,
	input  logic [7:0]         task_id,
	input  logic [1:0]         task_type,
	input  logic               resumed,
	input  logic               yielded,
	input  logic [31:0]        now,
	input  logic [31:0]        raster_clock,
	input  logic [31:0]        raster_command,
	input  logic [31:0]        raster_pipe,
	input  logic [31:0]        raster_texmem,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         metric_index,
	output logic [31:0]        metric_value,
	output logic               sample_valid,
	output logic               last_item
);

	localparam int AW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int FW  = $clog2(HISTORY_DEPTH + 1);
	localparam int HTW = 32 + $clog2(HISTORY_DEPTH);
	localparam int DCW = $clog2(HTW);
	localparam int NM  = ttp_pkg::NUM_METRICS;

	// architectural state
	logic [7:0]  gtask_q, atask_q;
	logic [31:0] fstart_q, rstart_q, abegin_q, pbegin_q, rbegin_q;
	logic [5:0]  flags_q;
	logic [31:0] seq_q;
	logic [31:0] act_q [NM];
	logic [31:0] lat_q [NM];
	logic [AW-1:0]  ptr_q;
	logic [FW-1:0]  fill_q;
	logic [HTW-1:0] htot_q;

	// publish working registers
	logic [31:0]    now_q, total_q;
	logic [HTW-1:0] dq_q;
	logic [FW-1:0]  rem_q;
	logic [DCW-1:0] dcnt_q;
	logic [FW-1:0]  sc_q;
	logic           rv_q;
	logic [31:0]    mx_q;

	// history ring
	logic [31:0]   mem [HISTORY_DEPTH];
	logic [31:0]   mem_rdata_q;
	logic [AW-1:0] rd_addr;

	// output register
	logic        ovld_q;
	logic [3:0]  oidx_q;
	logic [31:0] oval_q;
	logic        osv_q;
	logic        olast_q;
	logic [3:0]  qidx_q;

	// event next-state values
	logic [7:0]  n_gt, n_at;
	logic [31:0] n_fs, n_rs, n_ab, n_pb, n_rb;
	logic [5:0]  n_fl;
	logic [31:0] n_seq;
	logic [31:0] n_act [NM];
	logic [31:0] lat;
	logic [31:0] rend;
	logic        pub;

	// apply one event
	always_comb begin
		n_gt  = gtask_q;
		n_at  = atask_q;
		n_fs  = fstart_q;
		n_rs  = rstart_q;
		n_ab  = abegin_q;
		n_pb  = pbegin_q;
		n_rb  = rbegin_q;
		n_fl  = flags_q;
		n_seq = seq_q;
		n_act = act_q;
		lat   = now - rbegin_q;
		rend  = now - fstart_q;
		pub   = 1'b0;
		case (func)
			ttp_pkg::FN_START: begin
				if (task_type == ttp_pkg::TT_AUDIO) begin
					n_at = task_id;
					n_ab = now;
				end else if (task_type == ttp_pkg::TT_GRAPHICS) begin
					if (!resumed) begin
						for (int k = 0; k < NM; k++) begin
							n_act[k] = '0;
						end
						n_gt                   = task_id;
						n_fs                   = now;
						n_fl[ttp_pkg::FL_PAUSE] = 1'b0;
						n_fl[ttp_pkg::FL_YPEND] = 1'b0;
						n_fl[ttp_pkg::FL_PDONE] = 1'b0;
						n_fl[ttp_pkg::FL_RDONE] = 1'b0;
						n_seq                  = seq_q + 32'd1;
						n_act[ttp_pkg::M_SEQ]  = n_seq;
					end
					if (task_id == n_gt) begin
						if (n_fl[ttp_pkg::FL_PAUSE]) begin
							n_act[ttp_pkg::M_YTICKS] = n_act[ttp_pkg::M_YTICKS] + (now - pbegin_q);
							n_fl[ttp_pkg::FL_PAUSE]  = 1'b0;
						end
						n_rs                  = now;
						n_fl[ttp_pkg::FL_RUN] = 1'b1;
					end
				end
			end
			ttp_pkg::FN_YREQ: begin
				if (task_id == gtask_q && flags_q[ttp_pkg::FL_RUN]
						&& !flags_q[ttp_pkg::FL_YPEND]) begin
					n_fl[ttp_pkg::FL_YPEND] = 1'b1;
					n_rb                    = now;
				end
			end
			ttp_pkg::FN_PDONE: begin
				if (task_id == atask_q) begin
					if (gtask_q != 8'd0) begin
						n_act[ttp_pkg::M_AUDIO] = act_q[ttp_pkg::M_AUDIO] + (now - abegin_q);
					end
					n_at = 8'd0;
				end else if (task_id == gtask_q && flags_q[ttp_pkg::FL_RUN]) begin
					n_act[ttp_pkg::M_PROC] = act_q[ttp_pkg::M_PROC] + (now - rstart_q);
					n_fl[ttp_pkg::FL_RUN]  = 1'b0;
					if (yielded) begin
						n_act[ttp_pkg::M_YCOUNT] = act_q[ttp_pkg::M_YCOUNT] + 32'd1;
						n_fl[ttp_pkg::FL_PAUSE]  = 1'b1;
						n_pb                     = now;
						if (flags_q[ttp_pkg::FL_YPEND] && lat > act_q[ttp_pkg::M_YLAT]) begin
							n_act[ttp_pkg::M_YLAT] = lat;
						end
					end else begin
						n_fl[ttp_pkg::FL_PDONE] = 1'b1;
					end
					n_fl[ttp_pkg::FL_YPEND] = 1'b0;
					pub                     = 1'b1;
				end
			end
			ttp_pkg::FN_RDONE: begin
				if (task_id == gtask_q && !flags_q[ttp_pkg::FL_RDONE]) begin
					n_act[ttp_pkg::M_REND]  = rend;
					n_act[ttp_pkg::M_RCLK]  = {8'd0, raster_clock[23:0]};
					n_act[ttp_pkg::M_RCMD]  = {8'd0, raster_command[23:0]};
					n_act[ttp_pkg::M_RPIPE] = {8'd0, raster_pipe[23:0]};
					n_act[ttp_pkg::M_RTMEM] = {8'd0, raster_texmem[23:0]};
					n_act[ttp_pkg::M_RANGE] = {31'd0, (rend >= {8'd0, range_threshold})};
					n_fl[ttp_pkg::FL_RDONE] = 1'b1;
					pub                     = 1'b1;
				end
			end
			ttp_pkg::FN_CLEAR: begin
				n_gt  = '0;
				n_at  = '0;
				n_fs  = '0;
				n_rs  = '0;
				n_ab  = '0;
				n_pb  = '0;
				n_rb  = '0;
				n_fl  = '0;
				n_seq = '0;
				for (int k = 0; k < NM; k++) begin
					n_act[k] = '0;
				end
			end
			default: begin
			end
		endcase
	end

	// division step
	logic [FW:0]    trial;
	logic           ge;
	logic [FW-1:0]  rem_n;
	assign trial = {rem_q, dq_q[HTW-1]};
	assign ge    = (trial >= {1'b0, fill_q});
	assign rem_n = ge ? FW'(trial - {1'b0, fill_q}) : trial[FW-1:0];

	// ring update values
	logic           full;
	logic [31:0]    old_total;
	logic [HTW-1:0] htot_n;
	logic [FW-1:0]  fill_n;
	assign full      = (fill_q == FW'(HISTORY_DEPTH));
	assign old_total = full ? mem_rdata_q : 32'd0;
	assign htot_n    = htot_q - HTW'(old_total) + HTW'(total_q);
	assign fill_n    = full ? fill_q : fill_q + 1'b1;

	// status
	assign stat.pub_need = pub && n_fl[ttp_pkg::FL_PDONE] && n_fl[ttp_pkg::FL_RDONE];
	assign stat.query    = (func == ttp_pkg::FN_QUERY);
	assign stat.div_done = (dcnt_q == DCW'(HTW - 1));
	assign stat.max_done = (sc_q == fill_q) && !rv_q;
	assign stat.out_free = !ovld_q || !out_stall;
	assign stat.q_last   = (qidx_q == 4'd15);

	// task state and metrics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gtask_q  <= '0;
			atask_q  <= '0;
			fstart_q <= '0;
			rstart_q <= '0;
			abegin_q <= '0;
			pbegin_q <= '0;
			rbegin_q <= '0;
			flags_q  <= '0;
			seq_q    <= '0;
			for (int k = 0; k < NM; k++) begin
				act_q[k] <= '0;
				lat_q[k] <= '0;
			end
		end else if (cmd.exec) begin
			gtask_q  <= n_gt;
			atask_q  <= n_at;
			fstart_q <= n_fs;
			rstart_q <= n_rs;
			abegin_q <= n_ab;
			pbegin_q <= n_pb;
			rbegin_q <= n_rb;
			flags_q  <= n_fl;
			seq_q    <= n_seq;
			act_q    <= n_act;
			if (func == ttp_pkg::FN_CLEAR) begin
				for (int k = 0; k < NM; k++) begin
					lat_q[k] <= '0;
				end
			end
		end else if (cmd.pub_read) begin
			act_q[ttp_pkg::M_TOTAL] <= now_q - fstart_q;
			if (atask_q != 8'd0) begin
				act_q[ttp_pkg::M_AUDIO] <= act_q[ttp_pkg::M_AUDIO] + (now_q - abegin_q);
			end
		end else if (cmd.finish) begin
			act_q[ttp_pkg::M_HCOUNT] <= 32'(fill_q);
			act_q[ttp_pkg::M_AVG]    <= dq_q[31:0];
			act_q[ttp_pkg::M_MAX]    <= mx_q;
			for (int k = 0; k < NM; k++) begin
				if (k != int'(ttp_pkg::M_HCOUNT) && k != int'(ttp_pkg::M_AVG)
						&& k != int'(ttp_pkg::M_MAX)) begin
					lat_q[k] <= act_q[k];
				end
			end
			lat_q[ttp_pkg::M_HCOUNT]  <= 32'(fill_q);
			lat_q[ttp_pkg::M_AVG]     <= dq_q[31:0];
			lat_q[ttp_pkg::M_MAX]     <= mx_q;
			flags_q[ttp_pkg::FL_VALID] <= 1'b1;
			gtask_q                   <= 8'd0;
		end
	end

	// ring pointer, fill count and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			fill_q <= '0;
			htot_q <= '0;
		end else if (cmd.exec && func == ttp_pkg::FN_CLEAR) begin
			ptr_q  <= '0;
			fill_q <= '0;
			htot_q <= '0;
		end else if (cmd.pub_write) begin
			ptr_q  <= (ptr_q == AW'(HISTORY_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
			fill_q <= fill_n;
			htot_q <= htot_n;
		end
	end

	// publish working registers: divider and maximum sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
			sc_q   <= '0;
			rv_q   <= 1'b0;
		end else if (cmd.pub_write) begin
			dcnt_q <= '0;
			sc_q   <= '0;
			rv_q   <= 1'b0;
		end else if (cmd.div_run) begin
			dcnt_q <= dcnt_q + 1'b1;
		end else if (cmd.max_run) begin
			rv_q <= (sc_q < fill_q);
			if (sc_q < fill_q) begin
				sc_q <= sc_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			now_q <= now;
		end
		if (cmd.pub_read) begin
			total_q <= now_q - fstart_q;
		end
		if (cmd.pub_write) begin
			dq_q  <= htot_n;
			rem_q <= '0;
			mx_q  <= '0;
		end else if (cmd.div_run) begin
			dq_q  <= {dq_q[HTW-2:0], ge};
			rem_q <= rem_n;
		end else if (cmd.max_run && rv_q && mem_rdata_q > mx_q) begin
			mx_q <= mem_rdata_q;
		end
	end

	// history memory
	assign rd_addr = cmd.pub_read ? ptr_q : sc_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.pub_write) begin
			mem[ptr_q] <= total_q;
		end
		mem_rdata_q <= mem[rd_addr];
	end

	// query output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
			qidx_q <= '0;
		end else if (cmd.q_load) begin
			ovld_q <= 1'b1;
			qidx_q <= qidx_q + 1'b1;
		end else if (!out_stall) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.q_load) begin
			oidx_q  <= qidx_q;
			oval_q  <= lat_q[qidx_q];
			osv_q   <= flags_q[ttp_pkg::FL_VALID];
			olast_q <= (qidx_q == 4'd15);
		end
	end

	assign out_valid    = ovld_q;
	assign metric_index = oidx_q;
	assign metric_value = oval_q;
	assign sample_valid = osv_q;
	assign last_item    = olast_q;

endmodule

>>> sv/task_timing_profiler_core.sv
// ----------------------------------------------------------------------------
// task_timing_profiler_core
// Task timing profiler: per-frame graphics task timing with history ring.
// ----------------------------------------------------------------------------
// One event beat is taken per cycle while idle. An event that completes a
// frame starts the publish sequence: ring read, ring write, a restoring
// divider that retires one quotient bit a cycle, then a sweep over the filled
// ring entries through the read port of the history memory, then the copy into
// the latest sample; the input stays stalled until the copy is done.
// A query streams 16 result beats, one per cycle when the output is not
// stalled. No clearing pass: the fill count masks unwritten ring entries.
module task_timing_profiler_core #(
	parameter int HISTORY_DEPTH = ttp_pkg::HIST_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [7:0]  task_id,
	input  logic [1:0]  task_type,
	input  logic        resumed,
	input  logic        yielded,
	input  logic [31:0] now,
	input  logic [31:0] raster_clock,
	input  logic [31:0] raster_command,
	input  logic [31:0] raster_pipe,
	input  logic [31:0] raster_texmem,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  metric_index,
	output logic [31:0] metric_value,
	output logic        sample_valid,
	output logic        last_item
);

	ttp_pkg::ctrl_cmd_t cmd;
	ttp_pkg::dp_stat_t  stat;
	logic [23:0]        thresh_q;

	// configuration register
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {8'd0, thresh_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= ttp_pkg::THRESH_RESET;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			thresh_q <= pwdata[23:0];
		end
	end

	ttp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	ttp_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.range_threshold (thresh_q),
		.func            (func),
		.task_id         (task_id),
		.task_type       (task_type),
		.resumed         (resumed),
		.yielded         (yielded),
		.now             (now),
		.raster_clock    (raster_clock),
		.raster_command  (raster_command),
		.raster_pipe     (raster_pipe),
		.raster_texmem   (raster_texmem),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.metric_index    (metric_index),
		.metric_value    (metric_value),
		.sample_valid    (sample_valid),
		.last_item       (last_item)
	);

	// at most one command per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("controller issued overlapping commands");

	// a query beat blocks the input on the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && func == ttp_pkg::FN_QUERY) |=> in_stall)
		else $error("query did not start the response burst");

	// last beat carries the final metric
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_item) |-> (metric_index == ttp_pkg::M_MAX))
		else $error("last beat with wrong metric index");

	// no published sample means all metrics read zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !sample_valid) |-> (metric_value == 32'd0))
		else $error("nonzero metric without a published sample");

endmodule

>>> tb/tb_checker.sv
// ----------------------------------------------------------------------------
// tb_checker
// Watches the event and metric channels of the task timing profiler,
// tracks frame timing state from accepted event beats and checks every
// metric beat against the predicted snapshot stream.
// ----------------------------------------------------------------------------
module tb_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  func,
	input  logic [7:0]  task_id,
	input  logic [1:0]  task_type,
	input  logic        resumed,
	input  logic        yielded,
	input  logic [31:0] now,
	input  logic [31:0] raster_clock,
	input  logic [31:0] raster_command,
	input  logic [31:0] raster_pipe,
	input  logic [31:0] raster_texmem,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [3:0]  metric_index,
	input  logic [31:0] metric_value,
	input  logic        sample_valid,
	input  logic        last_item,
	input  logic        thr_we,
	input  logic [23:0] thr_val,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = ttp_pkg::HIST_DEPTH_DEF;
	localparam int NM    = ttp_pkg::NUM_METRICS;

	typedef struct packed {
		logic [3:0]  idx;
		logic [31:0] val;
		logic        sv;
		logic        last;
	} metric_beat_t;

	metric_beat_t snapshot_q[$];

	logic [23:0] threshold;
	logic [7:0]  gfx_task, aud_task;
	logic [31:0] frame_t0, run_t0, aud_t0, pause_t0, req_t0;
	logic [5:0]  flags;
	logic [31:0] seq_cnt;
	logic [31:0] ring [DEPTH];
	int          ring_ptr, ring_fill;
	logic [37:0] ring_sum;
	logic [31:0] act [NM];
	logic [31:0] pub [NM];

	assign pending = snapshot_q.size();

	task automatic clear_profile();
		gfx_task = '0; aud_task = '0;
		frame_t0 = '0; run_t0 = '0; aud_t0 = '0; pause_t0 = '0; req_t0 = '0;
		flags = '0; seq_cnt = '0;
		foreach (ring[i]) ring[i] = '0;
		ring_ptr = 0; ring_fill = 0; ring_sum = '0;
		foreach (act[i]) act[i] = '0;
		foreach (pub[i]) pub[i] = '0;
	endtask

	// complete the frame once both processor and raster are done
	task automatic publish_frame(input logic [31:0] t);
		logic [31:0] tot, mx;
		if (!flags[ttp_pkg::FL_PDONE] || !flags[ttp_pkg::FL_RDONE])
			return;
		if (aud_task != 0)
			act[ttp_pkg::M_AUDIO] += t - aud_t0;
		tot = t - frame_t0;
		act[ttp_pkg::M_TOTAL] = tot;
		ring_sum = ring_sum - ring[ring_ptr] + tot;
		ring[ring_ptr] = tot;
		ring_ptr = (ring_ptr + 1) % DEPTH;
		if (ring_fill < DEPTH)
			ring_fill++;
		act[ttp_pkg::M_HCOUNT] = ring_fill;
		act[ttp_pkg::M_AVG] = 32'(ring_sum / ring_fill);
		mx = '0;
		for (int i = 0; i < ring_fill; i++)
			if (ring[i] > mx) mx = ring[i];
		act[ttp_pkg::M_MAX] = mx;
		pub = act;
		flags[ttp_pkg::FL_VALID] = 1'b1;
		gfx_task = '0;
	endtask

	task automatic apply_event();
		logic [31:0] lat, rend;
		case (func)
			ttp_pkg::FN_START: begin
				if (task_type == ttp_pkg::TT_AUDIO) begin
					aud_task = task_id;
					aud_t0 = now;
				end else if (task_type == ttp_pkg::TT_GRAPHICS) begin
					if (!resumed) begin
						foreach (act[i]) act[i] = '0;
						gfx_task = task_id;
						frame_t0 = now;
						flags[ttp_pkg::FL_PAUSE] = 0; flags[ttp_pkg::FL_YPEND] = 0;
						flags[ttp_pkg::FL_PDONE] = 0; flags[ttp_pkg::FL_RDONE] = 0;
						seq_cnt++;
						act[ttp_pkg::M_SEQ] = seq_cnt;
					end
					if (task_id == gfx_task) begin
						if (flags[ttp_pkg::FL_PAUSE]) begin
							act[ttp_pkg::M_YTICKS] += now - pause_t0;
							flags[ttp_pkg::FL_PAUSE] = 0;
						end
						run_t0 = now;
						flags[ttp_pkg::FL_RUN] = 1;
					end
				end
			end
			ttp_pkg::FN_YREQ: begin
				if (task_id == gfx_task && flags[ttp_pkg::FL_RUN]
						&& !flags[ttp_pkg::FL_YPEND]) begin
					flags[ttp_pkg::FL_YPEND] = 1;
					req_t0 = now;
				end
			end
			ttp_pkg::FN_PDONE: begin
				if (task_id == aud_task) begin
					if (gfx_task != 0)
						act[ttp_pkg::M_AUDIO] += now - aud_t0;
					aud_task = '0;
				end else if (task_id == gfx_task && flags[ttp_pkg::FL_RUN]) begin
					act[ttp_pkg::M_PROC] += now - run_t0;
					flags[ttp_pkg::FL_RUN] = 0;
					if (yielded) begin
						act[ttp_pkg::M_YCOUNT]++;
						flags[ttp_pkg::FL_PAUSE] = 1;
						pause_t0 = now;
						if (flags[ttp_pkg::FL_YPEND]) begin
							lat = now - req_t0;
							if (lat > act[ttp_pkg::M_YLAT]) act[ttp_pkg::M_YLAT] = lat;
						end
					end else begin
						flags[ttp_pkg::FL_PDONE] = 1;
					end
					flags[ttp_pkg::FL_YPEND] = 0;
					publish_frame(now);
				end
			end
			ttp_pkg::FN_RDONE: begin
				if (task_id == gfx_task && !flags[ttp_pkg::FL_RDONE]) begin
					rend = now - frame_t0;
					act[ttp_pkg::M_REND] = rend;
					act[ttp_pkg::M_RCLK] = {8'h0, raster_clock[23:0]};
					act[ttp_pkg::M_RCMD] = {8'h0, raster_command[23:0]};
					act[ttp_pkg::M_RPIPE] = {8'h0, raster_pipe[23:0]};
					act[ttp_pkg::M_RTMEM] = {8'h0, raster_texmem[23:0]};
					act[ttp_pkg::M_RANGE] = (rend >= {8'h0, threshold}) ? 32'd1 : 32'd0;
					flags[ttp_pkg::FL_RDONE] = 1;
					publish_frame(now);
				end
			end
			ttp_pkg::FN_QUERY: begin
				for (int k = 0; k < NM; k++)
					snapshot_q.push_back({4'(k), pub[k], flags[ttp_pkg::FL_VALID],
						k == NM - 1});
			end
			ttp_pkg::FN_CLEAR: clear_profile();
			default: ;
		endcase
	endtask

	// track events, check metric beats
	always @(posedge clk or negedge arst_n) begin
		metric_beat_t exp_b;
		if (!arst_n) begin
			threshold = ttp_pkg::THRESH_RESET;
			clear_profile();
			snapshot_q.delete();
			fail_count = 0;
		end else begin
			if (thr_we)
				threshold = thr_val;
			if (in_valid && !in_stall)
				apply_event();
			if (out_valid && !out_stall) begin
				if (snapshot_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected metric beat idx=%0d val=%h",
							metric_index, metric_value);
				end else begin
					exp_b = snapshot_q.pop_front();
					if (exp_b != {metric_index, metric_value, sample_valid, last_item}) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch exp %0d %h %b %b got %0d %h %b %b",
								exp_b.idx, exp_b.val, exp_b.sv, exp_b.last,
								metric_index, metric_value, sample_valid, last_item);
					end
				end
			end
		end
	end
endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives task event sequences and threshold writes into the task timing
// profiler, with random gaps on both channels; the checker predicts results.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 0, arst_n = 0;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0, prdata;
	logic        pready;
	logic        in_valid = 0, in_stall;
	logic [2:0]  func = '0;
	logic [7:0]  task_id = '0;
	logic [1:0]  task_type = '0;
	logic        resumed = 0, yielded = 0;
	logic [31:0] now = '0, raster_clock = '0, raster_command = '0;
	logic [31:0] raster_pipe = '0, raster_texmem = '0;
	logic        out_valid, out_stall = 1;
	logic [3:0]  metric_index;
	logic [31:0] metric_value;
	logic        sample_valid, last_item;
	int          fail_count, pending;
	logic        thr_we;
	logic [31:0] clock_ticks;
	int          sent_cnt = 0;

	always #2 clk = ~clk;

	assign thr_we = psel && penable && pwrite && pready && paddr == 3'd0;

	task_timing_profiler_core u_top (.*);

	tb_checker u_chk (.clk, .arst_n, .in_valid, .in_stall, .func, .task_id,
		.task_type, .resumed, .yielded, .now, .raster_clock, .raster_command,
		.raster_pipe, .raster_texmem, .out_valid, .out_stall, .metric_index,
		.metric_value, .sample_valid, .last_item, .thr_we,
		.thr_val(pwdata[23:0]), .fail_count, .pending);

	// receiver stall: hold each beat for a randomly drawn time, then take it
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (out_valid) begin
				n = $urandom_range(0, 19);
				repeat (n) @(posedge clk);
				out_stall <= 0;
				@(posedge clk);
				out_stall <= 1;
			end
		end
	end

	task automatic send_event(input logic [2:0] f, input logic [7:0] id,
			input logic [1:0] tt, input logic r, input logic y, input logic [31:0] dt);
		int gap;
		gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
		repeat (gap) @(posedge clk);
		clock_ticks += dt;
		func <= f; task_id <= id; task_type <= tt; resumed <= r; yielded <= y;
		now <= clock_ticks;
		raster_clock <= $urandom; raster_command <= $urandom;
		raster_pipe <= $urandom; raster_texmem <= $urandom;
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		in_valid <= 0;
		sent_cnt++;
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [31:0] v);
		drain();
		psel <= 1; pwrite <= 1; paddr <= 3'd0; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_dt();
		case ($urandom_range(0, 3))
			0: rand_dt = $urandom;
			1: rand_dt = $urandom_range(0, 100);
			default: rand_dt = $urandom_range(0, 32'h00ff_ffff);
		endcase
	endfunction

	// one graphics frame with yields, audio overlap and raster done
	task automatic frame_seq(input logic [7:0] g);
		int ny;
		logic [7:0] a;
		a = 8'($urandom_range(1, 255));
		if (a == g) a = a ^ 8'h80;
		send_event(ttp_pkg::FN_START, g, ttp_pkg::TT_GRAPHICS, 0, 0, rand_dt());
		if ($urandom_range(0, 1))
			send_event(ttp_pkg::FN_START, a, ttp_pkg::TT_AUDIO, 0, 0, rand_dt());
		ny = $urandom_range(0, 3);
		for (int i = 0; i < ny; i++) begin
			if ($urandom_range(0, 1)) send_event(ttp_pkg::FN_YREQ, g, 0, 0, 0, rand_dt());
			send_event(ttp_pkg::FN_PDONE, g, 0, 0, 1, rand_dt());
			send_event(ttp_pkg::FN_START, g, ttp_pkg::TT_GRAPHICS, 1, 0, rand_dt());
		end
		if ($urandom_range(0, 1)) send_event(ttp_pkg::FN_PDONE, a, 0, 0, 0, rand_dt());
		if ($urandom_range(0, 1)) begin
			send_event(ttp_pkg::FN_RDONE, g, 0, 0, 0, rand_dt());
			send_event(ttp_pkg::FN_PDONE, g, 0, 0, 0, rand_dt());
		end else begin
			send_event(ttp_pkg::FN_PDONE, g, 0, 0, 0, rand_dt());
			send_event(ttp_pkg::FN_RDONE, g, 0, 0, 0, rand_dt());
		end
		if ($urandom_range(0, 2) == 0) send_event(ttp_pkg::FN_QUERY, 0, 0, 0, 0, 0);
	endtask

	initial begin
		logic mid_done;
		clock_ticks = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty query, ignored codes and types, edge frames
		send_event(ttp_pkg::FN_QUERY, 0, 0, 0, 0, 0);
		send_event(3'd6, 8'hff, 2'd3, 1, 1, 32'hffff_ffff);
		send_event(3'd7, 0, 0, 0, 0, 0);
		send_event(ttp_pkg::FN_START, 8'h33, 2'd2, 0, 0, 5);
		send_event(ttp_pkg::FN_START, 8'h33, 2'd3, 1, 1, 5);
		send_event(ttp_pkg::FN_QUERY, 0, 0, 0, 0, 0);
		frame_seq(8'hff);
		send_event(ttp_pkg::FN_RDONE, 8'h00, 0, 0, 0, 3);
		frame_seq(8'h01);
		send_event(ttp_pkg::FN_QUERY, 0, 0, 0, 0, 0);
		// task id 0 frame and repeated raster done
		send_event(ttp_pkg::FN_START, 8'h00, ttp_pkg::TT_GRAPHICS, 0, 0, 32'hffff_fff0);
		send_event(ttp_pkg::FN_RDONE, 8'h00, 0, 0, 0, 32'h00ff_ffff);
		send_event(ttp_pkg::FN_RDONE, 8'h00, 0, 0, 0, 1);
		send_event(ttp_pkg::FN_PDONE, 8'h00, 0, 0, 0, 7);
		send_event(ttp_pkg::FN_QUERY, 0, 0, 0, 0, 0);
		send_event(ttp_pkg::FN_CLEAR, 0, 0, 0, 0, 0);
		send_event(ttp_pkg::FN_QUERY, 0, 0, 0, 0, 0);

		write_threshold(32'h0000_0000);
		frame_seq(8'h10);
		write_threshold(32'hffff_ffff);
		frame_seq(8'h20);
		write_threshold(32'h0000_0040);

		// random: mostly well-formed frames, some noise
		mid_done = 1'b0;
		while (sent_cnt < 460) begin
			if ($urandom_range(0, 4) == 0) begin
				send_event(3'($urandom_range(0, 7)), 8'($urandom),
					2'($urandom), 1'($urandom), 1'($urandom), rand_dt());
			end else begin
				frame_seq(8'($urandom_range(0, 255)));
			end
			if ($urandom_range(0, 40) == 0) send_event(ttp_pkg::FN_CLEAR, 0, 0, 0, 0, 0);
			if (!mid_done && sent_cnt > 230) begin
				drain();
				write_threshold(32'($urandom_range(0, 32'h00ff_ffff)));
				mid_done = 1'b1;
			end
		end
		send_event(ttp_pkg::FN_QUERY, 0, 0, 0, 0, 0);
		drain();
		if (fail_count == 0 && pending == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb_top failed");
		$finish;
	end
endmodule
